// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the point record decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Types and constants of the tracker point record decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

  // Record layout: seven words, each sent as a low and a high byte.
  localparam int WORDS_PER_RECORD = 7;
  localparam int BYTES_PER_RECORD = 2 * WORDS_PER_RECORD;
  localparam int IDX_W            = $clog2(BYTES_PER_RECORD);
  localparam int WORD_W           = 16;
  localparam int PAYLOAD_W        = 7;

  localparam logic [IDX_W-1:0] FIRST_IDX = '0;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BYTES_PER_RECORD - 1);

  typedef logic [WORD_W-1:0] word_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ZERO  = 2'd1,
    STATUS_PHASE = 2'd2
  } status_e;

endpackage

`default_nettype wire

// File: sv/tpd_word_cell.sv
// ----------------------------------------------------------------------------
// tpd_word_cell
// One cell of the word chain: holds one assembled word and passes it on
// to its neighbor whenever a new word enters the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_word_cell
  import tpd_pkg::*;
(
  input  wire        clk_i,
  input  wire        shift_i,
  input  wire word_t word_i,
  output word_t      word_o
);

  word_t word_q;
  word_t word_d;

  // Take the neighbor's word on a shift, otherwise hold.
  always_comb begin
    word_d = shift_i ? word_i : word_q;
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

// File: sv/tracker_point_record_decoder.sv
// ----------------------------------------------------------------------------
// tracker_point_record_decoder
// Decodes the 14-byte position and quaternion point record of a magnetic
// tracker, one serial byte per word, into one status, a start-bit flag and seven raw words.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   input    in         in_valid_i/in_ready_o   rx_byte_i, record_start_i
//   output   out        out_valid_o/out_ready_i status_o .. quat_3_o
//
// A new byte may be accepted in every cycle, except when the input stalls.
// The record result enters the output register in the cycle after its
// last byte is accepted. The input stalls only on the last byte of a record
// while the previous result is still held and not being taken.
// Reset clears the byte count, the low byte, the error flags and the output valid, and sets the zero flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tracker_point_record_decoder
  import tpd_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [7:0]         rx_byte_i,
  input  wire                record_start_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [1:0]         status_o,
  output logic               start_bit_missing_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic signed [15:0] quat_0_o,
  output logic signed [15:0] quat_1_o,
  output logic signed [15:0] quat_2_o,
  output logic signed [15:0] quat_3_o
);

  // Record progress state.
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [PAYLOAD_W-1:0] low_q, low_d;
  logic                 zero_q, zero_d;
  logic                 phase_err_q, phase_err_d;
  logic                 start_miss_q, start_miss_d;

  // Output register.
  logic    out_valid_q, out_valid_d;
  status_e status_q, status_d;
  logic    miss_out_q, miss_out_d;
  word_t   words_q [WORDS_PER_RECORD];
  word_t   words_d [WORDS_PER_RECORD];

  logic             accept;
  logic             emit;
  logic [IDX_W-1:0] idx_cur;
  logic             zero_base;
  logic             err_base;
  logic             miss_base;
  word_t            new_word;
  logic             shift;
  word_t            chain_w [WORDS_PER_RECORD-1];

  // Only the last byte of a record needs room in the output register.
  assign in_ready_o = !out_valid_q || out_ready_i || (idx_cur != LAST_IDX);
  assign accept     = in_valid_i && in_ready_o;

  // A start marker rearms the record before this byte is used.
  assign idx_cur   = record_start_i ? FIRST_IDX : idx_q;
  assign zero_base = record_start_i ? 1'b1 : zero_q;
  assign err_base  = record_start_i ? 1'b0 : phase_err_q;
  assign miss_base = record_start_i ? 1'b0 : start_miss_q;
  assign emit      = accept && (idx_cur == LAST_IDX);

  // A high byte completes a word: seven plus seven bits, scaled by four.
  assign new_word = {rx_byte_i[PAYLOAD_W-1:0], low_q, 2'b00};
  assign shift    = accept && idx_cur[0];

  // Chain of word cells; the newest word enters cell zero. The last word of
  // a record goes straight to the output register.
  for (genvar g = 0; g < WORDS_PER_RECORD - 1; g++) begin : g_cell
    tpd_word_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .word_i ((g == 0) ? new_word : chain_w[(g == 0) ? 0 : g - 1]),
      .word_o (chain_w[g])
    );
  end

  // Byte count, low byte and record flags.
  always_comb begin
    idx_d        = idx_q;
    low_d        = low_q;
    zero_d       = zero_q;
    phase_err_d  = phase_err_q;
    start_miss_d = start_miss_q;
    if (accept) begin
      if (!idx_cur[0]) begin
        low_d = rx_byte_i[PAYLOAD_W-1:0];
      end
      if (emit) begin
        idx_d        = FIRST_IDX;
        zero_d       = 1'b1;
        phase_err_d  = 1'b0;
        start_miss_d = 1'b0;
      end else begin
        idx_d       = idx_cur + 1'b1;
        zero_d      = zero_base && (rx_byte_i == 8'h00);
        phase_err_d = err_base;
        if (idx_cur == FIRST_IDX) begin
          start_miss_d = !rx_byte_i[7];
        end else begin
          start_miss_d = miss_base;
          phase_err_d  = err_base || rx_byte_i[7];
        end
      end
    end
  end

  // Result on the last byte; words of a rejected record read as zero.
  always_comb begin
    logic rec_zero;
    logic rec_err;
    rec_zero    = zero_base && (rx_byte_i == 8'h00);
    rec_err     = err_base || rx_byte_i[7];
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    miss_out_d  = miss_out_q;
    words_d     = words_q;
    if (emit) begin
      out_valid_d = 1'b1;
      for (int k = 0; k < WORDS_PER_RECORD; k++) begin
        if (k == WORDS_PER_RECORD - 1) begin
          words_d[k] = new_word;
        end else begin
          words_d[k] = chain_w[WORDS_PER_RECORD - 2 - k];
        end
      end
      if (rec_zero) begin
        status_d   = STATUS_ZERO;
        miss_out_d = 1'b0;
        for (int k = 0; k < WORDS_PER_RECORD; k++) words_d[k] = '0;
      end else if (rec_err) begin
        status_d   = STATUS_PHASE;
        miss_out_d = miss_base;
        for (int k = 0; k < WORDS_PER_RECORD; k++) words_d[k] = '0;
      end else begin
        status_d   = STATUS_OK;
        miss_out_d = miss_base;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= FIRST_IDX;
      low_q        <= '0;
      zero_q       <= 1'b1;
      phase_err_q  <= 1'b0;
      start_miss_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      low_q        <= low_d;
      zero_q       <= zero_d;
      phase_err_q  <= phase_err_d;
      start_miss_q <= start_miss_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    miss_out_q <= miss_out_d;
    words_q    <= words_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign start_bit_missing_o = miss_out_q;
  assign pos_x_o             = words_q[0];
  assign pos_y_o             = words_q[1];
  assign pos_z_o             = words_q[2];
  assign quat_0_o            = words_q[3];
  assign quat_1_o            = words_q[4];
  assign quat_2_o            = words_q[5];
  assign quat_3_o            = words_q[6];

  // Checks on the decoder's own logic.
  `ASSERT_NEXT(a_emit_sets_valid, clk_i, rst_ni, emit,
               out_valid_o && (idx_q == FIRST_IDX))
  `ASSERT_IMP(a_zero_no_warn, clk_i, rst_ni,
              out_valid_o && (status_o == STATUS_ZERO), !start_bit_missing_o)
  `ASSERT_IMP(a_reject_zero_words, clk_i, rst_ni,
              out_valid_o && (status_o != STATUS_OK),
              (pos_x_o == 16'sd0) && (quat_3_o == 16'sd0))
  `ASSERT_IMP(a_stall_only_last, clk_i, rst_ni, !in_ready_o,
              (idx_q == LAST_IDX) && out_valid_o)

endmodule

`default_nettype wire

// File: sim/tb_tracker_point_record_decoder.sv
// ----------------------------------------------------------------------------
// tb_tracker_point_record_decoder
// Self-checking bench for the tracker point record decoder. Serial bytes are
// sent as input words through the valid/ready channel. A bit-level decoder
// model in the bench predicts each record result. Every result word is then
// compared field by field, in order. Directed records cover realignment,
// extreme words, a missing start bit, all-zero records and phasing errors.
// One long output stall follows, then random records with random idling on
// both sides and a final stretch with no idling.
// ----------------------------------------------------------------------------

module tb_tracker_point_record_decoder
  import tpd_pkg::*;
;

  localparam int LONG_HOLD_CYCLES = 200;
  localparam int RANDOM_BYTES     = 900;
  localparam int TAIL_RECORDS     = 10;
  localparam int DRAIN_LIMIT      = 4000;

  // One predicted record result.
  typedef struct packed {
    status_e                                 status;
    logic                                    start_missing;
    logic [WORDS_PER_RECORD-1:0][WORD_W-1:0] words;
  } record_result_t;

  logic clk_i  = 1'b0;
  logic rst_n  = 1'b0;

  logic       in_valid     = 1'b0;
  logic [7:0] rx_byte      = 8'h00;
  logic       record_start = 1'b0;
  logic       out_ready    = 1'b0;

  wire                in_ready;
  wire                out_valid;
  wire  [1:0]         status;
  wire                start_bit_missing;
  wire  signed [15:0] pos_x, pos_y, pos_z;
  wire  signed [15:0] quat_0, quat_1, quat_2, quat_3;

  // Decoder model state.
  logic [IDX_W-1:0]     rec_idx;
  logic [PAYLOAD_W-1:0] low_hold;
  word_t                word_buf [WORDS_PER_RECORD];
  logic                 zero_so_far;
  logic                 body_err;
  logic                 lead_missing;

  record_result_t expected_records [$];

  // Bench control and bookkeeping.
  bit hold_req = 1'b0;
  bit quiet    = 1'b0;
  int errors   = 0;
  int bytes_sent = 0;
  int n_checked  = 0;
  int n_ok = 0, n_zero = 0, n_phase = 0, n_missing = 0;

  string word_names [WORDS_PER_RECORD] =
    '{"pos_x", "pos_y", "pos_z", "quat_0", "quat_1", "quat_2", "quat_3"};

  always #2 clk_i = ~clk_i;

  tracker_point_record_decoder dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .rx_byte_i           (rx_byte),
    .record_start_i      (record_start),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .status_o            (status),
    .start_bit_missing_o (start_bit_missing),
    .pos_x_o             (pos_x),
    .pos_y_o             (pos_y),
    .pos_z_o             (pos_z),
    .quat_0_o            (quat_0),
    .quat_1_o            (quat_1),
    .quat_2_o            (quat_2),
    .quat_3_o            (quat_3)
  );

  // Clear the per-record state of the model, as the block does on rearm.
  function automatic void rearm_model();
    rec_idx      = FIRST_IDX;
    low_hold     = '0;
    zero_so_far  = 1'b1;
    body_err     = 1'b0;
    lead_missing = 1'b0;
  endfunction

  // Advance the model by one accepted byte; queue a result after the last byte.
  function automatic void decode_byte(input logic [7:0] rx, input logic first);
    logic [7:0]       b;
    logic [IDX_W-1:0] idx;
    record_result_t   rec;
    b = rx;
    if (first) rearm_model();
    if (rec_idx >= IDX_W'(BYTES_PER_RECORD)) rec_idx = FIRST_IDX;
    idx = rec_idx;
    // The all-zero test looks at the raw byte, phasing bit included.
    if (b != 8'h00) zero_so_far = 1'b0;
    if (idx == FIRST_IDX) begin
      lead_missing = ~b[7];
      b[7] = 1'b0;
    end else if (b[7]) begin
      body_err = 1'b1;
    end
    if (!idx[0]) begin
      low_hold = b[6:0];
    end else begin
      word_buf[idx >> 1] = {b[6:0], low_hold, 2'b00};
    end
    if (idx != LAST_IDX) begin
      rec_idx = idx + 1'b1;
    end else begin
      rec = '0;
      if (zero_so_far) begin
        rec.status = STATUS_ZERO;
        n_zero++;
      end else if (body_err) begin
        rec.status = STATUS_PHASE;
        rec.start_missing = lead_missing;
        n_phase++;
      end else begin
        rec.status = STATUS_OK;
        rec.start_missing = lead_missing;
        for (int k = 0; k < WORDS_PER_RECORD; k++) rec.words[k] = word_buf[k];
        n_ok++;
      end
      if (rec.start_missing) n_missing++;
      expected_records.push_back(rec);
      rearm_model();
    end
  endfunction

  // Seven payload bits, biased toward the extremes.
  function automatic logic [6:0] payload_bits();
    case ($urandom_range(0, 7))
      0: return 7'h00;
      1: return 7'h7f;
      default: return 7'($urandom);
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Compare one result word with the oldest pending record.
  task automatic check_record();
    record_result_t want;
    word_t          got [WORDS_PER_RECORD];
    if (expected_records.size() == 0) begin
      $error("result word arrived with no record pending");
      errors++;
    end else begin
      want = expected_records.pop_front();
      got = '{pos_x, pos_y, pos_z, quat_0, quat_1, quat_2, quat_3};
      compare_field("status", want.status, status);
      compare_field("start_bit_missing", want.start_missing, start_bit_missing);
      for (int k = 0; k < WORDS_PER_RECORD; k++) begin
        compare_field(word_names[k], want.words[k], got[k]);
      end
      n_checked++;
    end
  endtask

  // Inputs only change at rising edges, so the handshake is settled at the
  // falling edge and the word is taken at the following rising edge.
  always @(negedge clk_i) begin
    if (rst_n && out_valid && out_ready) check_record();
  end

  // Result side: random stall bursts, or one long hold when requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rst_n && !quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one input word and wait until it is taken. Must be called at a
  // rising edge; valid stays high afterwards unless a gap follows.
  task automatic send_byte(input logic [7:0] b, input logic first);
    in_valid     <= 1'b1;
    rx_byte      <= b;
    record_start <= first;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    decode_byte(b, first);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // A full record with random payload; bad_pos marks a body byte with bit 7 set.
  task automatic send_record(input logic [7:0] lead, input logic first,
                             input int bad_pos);
    logic [7:0] body;
    send_byte(lead, first);
    for (int pos = 1; pos < BYTES_PER_RECORD; pos++) begin
      body = {pos == bad_pos, payload_bits()};
      send_byte(body, 1'b0);
    end
  endtask

  // Drop valid and wait until every predicted record has come out or the drain limit runs out.
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (expected_records.size() != 0 && guard < DRAIN_LIMIT);
  endtask

  // A partial record with a bad body byte is discarded by a new record start.
  // The new record lacks its start bit and carries extreme words.
  task automatic test_realign_and_extremes();
    logic [7:0] pattern [BYTES_PER_RECORD];
    pattern = '{8'h7f, 8'h7f, 8'h00, 8'h40, 8'h7f, 8'h3f, 8'h00,
                8'h00, 8'h01, 8'h00, 8'h7f, 8'h7f, 8'h55, 8'h2a};
    send_byte(8'hc5, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h99, 1'b0);
    for (int i = 0; i < BYTES_PER_RECORD; i++) send_byte(pattern[i], i == 0);
  endtask

  // All-zero record, aligned by the byte count alone.
  task automatic test_all_zero_record();
    for (int i = 0; i < BYTES_PER_RECORD; i++) send_byte(8'h00, 1'b0);
  endtask

  // Phasing bit set in the last byte drops the record.
  task automatic test_phase_error();
    send_record(8'hff, 1'b1, BYTES_PER_RECORD - 1);
  endtask

  // Hold the result side long enough for the block to stall its input.
  task automatic test_output_backpressure();
    wait_for_results();
    @(negedge clk_i);
    hold_req = 1'b1;
    @(posedge clk_i);
    repeat (3) send_record({1'b1, payload_bits()}, 1'b1, -1);
    wait_for_results();
  endtask

  // Mostly well-formed records with random content, plus broken ones and noise.
  task automatic test_random_records(input int target);
    int start_count;
    int kind;
    start_count = bytes_sent;
    while (bytes_sent - start_count < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 66) begin
        send_record({1'b1, payload_bits()}, $urandom_range(0, 9) != 0, -1);
      end else if (kind < 74) begin
        send_record({1'b0, payload_bits()}, 1'b1, -1);
      end else if (kind < 82) begin
        send_record({1'($urandom_range(0, 1)), payload_bits()}, 1'b1,
                    $urandom_range(1, BYTES_PER_RECORD - 1));
      end else if (kind < 87) begin
        for (int i = 0; i < BYTES_PER_RECORD; i++) send_byte(8'h00, i == 0);
      end else if (kind < 94) begin
        // Truncated record; the next record start realigns it.
        send_byte({1'b1, payload_bits()}, 1'b1);
        repeat ($urandom_range(0, BYTES_PER_RECORD - 2)) begin
          send_byte({1'b0, payload_bits()}, 1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 20)) begin
          send_byte(8'($urandom), $urandom_range(0, 15) == 0);
        end
      end
    end
  endtask

  // Back-to-back records with no idling on either side.
  task automatic test_steady_stream();
    quiet = 1'b1;
    repeat (TAIL_RECORDS) send_record({1'b1, payload_bits()}, 1'b1, -1);
  endtask

  // Limit on the whole run.
  initial begin
    #1000000;
    $display("tracker_point_record_decoder test failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rearm_model();
    word_buf = '{default: '0};
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_realign_and_extremes();
    test_all_zero_record();
    test_phase_error();
    test_output_backpressure();
    test_random_records(RANDOM_BYTES);
    test_steady_stream();
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (expected_records.size() != 0) begin
      $error("%0d predicted records never came out", expected_records.size());
      errors++;
    end
    $display("Sent %0d input bytes and checked %0d records.", bytes_sent, n_checked);
    $display("Records: %0d valid, %0d all-zero, %0d phasing error, %0d missing start bit.",
             n_ok, n_zero, n_phase, n_missing);
    if (errors == 0) begin
      $display("tracker_point_record_decoder test passed");
    end else begin
      $display("tracker_point_record_decoder test failed");
    end
    $finish;
  end

endmodule
